/* rtl/rbpu_pkg.sv */
// Shared types and constants for the raw bit-packed unpacker.
// No dependencies; imported by every rbpu module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rbpu_pkg;

  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 12;
  localparam int CNT_W   = 14;
  localparam int PAD_W   = 12;
  localparam int MAX_PIX = 4;
  localparam int NPIX_W  = 3;

  localparam logic [CNT_W-1:0] MAX_ROW_PIXELS = 14'd8192;
  localparam logic [CNT_W-1:0] MAX_ROWS       = 14'd8192;

  // pixel_mode encodings
  localparam logic MODE_RAW10 = 1'b0;
  localparam logic MODE_RAW12 = 1'b1;

  // bytes per group and pixels per group for each mode
  localparam logic [3:0]        GROUP_BYTES_RAW10 = 4'd5;
  localparam logic [3:0]        GROUP_BYTES_RAW12 = 4'd3;
  localparam logic [NPIX_W-1:0] NPIX_RAW10        = 3'd4;
  localparam logic [NPIX_W-1:0] NPIX_RAW12        = 3'd2;

  typedef enum logic [1:0] {
    REG_PIXEL_MODE = 2'd0,
    REG_ROW_PIXELS = 2'd1,
    REG_FRAME_ROWS = 2'd2,
    REG_PAD_BYTES  = 2'd3
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // One completed group, handed from the unpacker to the output buffer.
  typedef struct packed {
    logic                       valid;
    logic [NPIX_W-1:0]          npix;
    pixel_t [MAX_PIX-1:0]       px;
    logic                       row_end;
    logic                       frame_end;
  } group_t;

endpackage

`default_nettype wire

/* rtl/rbpu_unpack.sv */
// Byte gatherer, LSB-first pixel unpacker and row/frame/padding counters.
// Depends on rbpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbpu_unpack import rbpu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              pixel_mode,
  input  logic [CNT_W-1:0]  row_pixels,
  input  logic [CNT_W-1:0]  frame_rows,
  input  logic [PAD_W-1:0]  pad_bytes,
  output logic              emit_next,
  output group_t            group
);

  logic [31:0]       gather_bytes, gather_bytes_next;
  logic [2:0]        byte_in_group, byte_in_group_next;
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [PAD_W-1:0]  pad_remaining, pad_remaining_next;
  logic              in_padding, in_padding_next;

  logic [3:0]        group_bytes;
  logic [NPIX_W-1:0] npix;
  logic [BYTE_W-1:0] b0, b1, b2, b3;
  logic [CNT_W-1:0]  width, rows;
  logic [CNT_W:0]    col_sum, row_sum;
  logic              rend, fend;
  pixel_t [MAX_PIX-1:0] px;

  assign group_bytes = (pixel_mode == MODE_RAW12) ? GROUP_BYTES_RAW12 : GROUP_BYTES_RAW10;
  assign npix        = (pixel_mode == MODE_RAW12) ? NPIX_RAW12 : NPIX_RAW10;

  // The current byte closes a group once the earlier bytes fill all but one slot.
  assign emit_next = !in_padding && (({1'b0, byte_in_group} + 4'd1) >= group_bytes);

  assign b0 = gather_bytes[7:0];
  assign b1 = gather_bytes[15:8];
  assign b2 = gather_bytes[23:16];
  assign b3 = gather_bytes[31:24];

  always_comb begin
    if (pixel_mode == MODE_RAW12) begin
      px[0] = {b1[3:0], b0};
      px[1] = {data_byte, b1[7:4]};
      px[2] = '0;
      px[3] = '0;
    end else begin
      px[0] = {2'b00, b1[1:0], b0};
      px[1] = {2'b00, b2[3:0], b1[7:2]};
      px[2] = {2'b00, b3[5:0], b2[7:4]};
      px[3] = {2'b00, data_byte, b3[7:6]};
    end
  end

  assign width   = (row_pixels > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : row_pixels;
  assign rows    = (frame_rows > MAX_ROWS) ? MAX_ROWS : frame_rows;
  assign col_sum = {1'b0, column_count} + {{(CNT_W + 1 - NPIX_W){1'b0}}, npix};
  assign row_sum = {1'b0, row_count} + {{CNT_W{1'b0}}, 1'b1};
  assign rend    = col_sum >= {1'b0, width};
  assign fend    = row_sum >= {1'b0, rows};

  always_comb begin
    group.valid     = accept && emit_next;
    group.npix      = npix;
    group.px        = px;
    group.row_end   = rend;
    group.frame_end = rend && fend;
  end

  always_comb begin
    gather_bytes_next  = gather_bytes;
    byte_in_group_next = byte_in_group;
    column_count_next  = column_count;
    row_count_next     = row_count;
    pad_remaining_next = pad_remaining;
    in_padding_next    = in_padding;
    if (accept) begin
      if (in_padding) begin
        // drop padding bytes
        if (pad_remaining != '0) begin
          pad_remaining_next = pad_remaining - {{(PAD_W-1){1'b0}}, 1'b1};
        end
        if (pad_remaining_next == '0) begin
          in_padding_next = 1'b0;
        end
      end else if (!emit_next) begin
        gather_bytes_next[{byte_in_group[1:0], 3'b000} +: 8] =
          gather_bytes[{byte_in_group[1:0], 3'b000} +: 8] | data_byte;
        byte_in_group_next = byte_in_group + 3'd1;
      end else begin
        gather_bytes_next  = '0;
        byte_in_group_next = '0;
        if (rend) begin
          column_count_next = '0;
          row_count_next    = fend ? '0 : row_sum[CNT_W-1:0];
          if (pad_bytes != '0) begin
            in_padding_next    = 1'b1;
            pad_remaining_next = pad_bytes;
          end
        end else begin
          column_count_next = col_sum[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather_bytes  <= '0;
      byte_in_group <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
      in_padding    <= 1'b0;
    end else begin
      gather_bytes  <= gather_bytes_next;
      byte_in_group <= byte_in_group_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_remaining <= pad_remaining_next;
      in_padding    <= in_padding_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rbpu_outbuf.sv */
// Result register for one group of up to four pixels, shifted out one per item.
// Depends on rbpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbpu_outbuf import rbpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  group_t      group,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [11:0] pixel, [15:12] zero
  output logic        m_tlast,  // last_of_run
  output logic [1:0]  m_tuser   // [0] row_end, [1] frame_end
);

  pixel_t            pix [MAX_PIX];
  logic [NPIX_W-1:0] remain;
  logic              rend, fend;
  logic              pop, last;

  assign pop      = (remain != '0) && m_tready;
  assign last     = (remain == {{(NPIX_W-1){1'b0}}, 1'b1});
  assign free     = (remain == '0) || (last && m_tready);
  assign m_tvalid = (remain != '0);
  assign m_tdata  = {4'b0000, pix[0]};
  assign m_tlast  = last;
  assign m_tuser  = {fend && last, rend && last};

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (group.valid) begin
      remain <= group.npix;
    end else if (pop) begin
      remain <= remain - {{(NPIX_W-1){1'b0}}, 1'b1};
    end
  end

  // load a fresh group, or advance the shift line by one pixel
  always_ff @(posedge clk) begin
    if (group.valid) begin
      for (int k = 0; k < MAX_PIX; k++) begin
        pix[k] <= group.px[k];
      end
      rend <= group.row_end;
      fend <= group.frame_end;
    end else if (pop) begin
      for (int k = 0; k < MAX_PIX - 1; k++) begin
        pix[k] <= pix[k+1];
      end
      pix[MAX_PIX-1] <= '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/raw_bit_packed_unpacker.sv */
// Top level of the raw bit-packed unpacker: configuration registers and stream ports.
// Depends on rbpu_pkg, rbpu_unpack and rbpu_outbuf.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packed raw byte per item and emits 12-bit pixels (10 or 12 significant
// bits) LSB-first, one pixel per item, tlast marking the last pixel of a group and
// tuser flagging row and frame ends. A byte is accepted every cycle unless stalled as
// below; a group's pixels appear in the cycle after its last byte and leave at one per
// cycle while m_tready is high, from a four-pixel shift register. Only the byte that
// closes a group can stall, and only while that register still holds more than one
// pixel or its last pixel is not being taken, so with a free-flowing output the input
// runs at one byte per cycle. Padding bytes after each row are swallowed at one per
// cycle. Write configuration only while the block is idle.

module raw_bit_packed_unpacker import rbpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] pixel, [15:12] zero
  output logic        m_tlast,   // last_of_run
  output logic [1:0]  m_tuser,   // [0] row_end, [1] frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  logic             pixel_mode;
  logic [CNT_W-1:0] row_pixels;
  logic [CNT_W-1:0] frame_rows;
  logic [PAD_W-1:0] pad_bytes;
  logic             emit_next;
  logic             free;
  logic             accept;
  group_t           group;

  assign cfg_ready = 1'b1;
  assign s_tready  = !emit_next || free;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= MODE_RAW10;
      row_pixels <= 14'd3840;
      frame_rows <= 14'd2160;
      pad_bytes  <= 12'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIXEL_MODE: pixel_mode <= cfg_data[0];
        REG_ROW_PIXELS: row_pixels <= cfg_data;
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        REG_PAD_BYTES:  pad_bytes  <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  rbpu_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .pixel_mode (pixel_mode),
    .row_pixels (row_pixels),
    .frame_rows (frame_rows),
    .pad_bytes  (pad_bytes),
    .emit_next  (emit_next),
    .group      (group)
  );

  rbpu_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .group    (group),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* verif/raw_bit_packed_unpacker_test.sv */
// Self-checking testbench for raw_bit_packed_unpacker: byte stream in, pixel stream out.
// Depends on rbpu_pkg and the RTL top; a behavioral unpacker predicts the pixels not typed into the directed table.
`timescale 1ns / 1ps

module raw_bit_packed_unpacker_test;
  import rbpu_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_PHASES      = 9;
  localparam int N_DIRECTED    = 37;

  typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;
  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_style_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         reg_idx;
    logic [13:0]      reg_val;
    logic [7:0]       data;
    logic [2:0]       ntyped;    // pixels typed in on this row, zero = predicted
    logic [3:0][11:0] px;
    logic             row_end;
    logic             frame_end;
  } stim_row_t;

  typedef struct packed {
    logic [11:0] pixel;
    logic        last;
    logic        row_end;
    logic        frame_end;
  } pix_item_t;

  // Reset defaults first, then 12-bit with one-group rows and one-row frames,
  // then a mode switch in the middle of a group, then clamped extremes.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd4, 48'h3FF3FF3FF3FF, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h00, 3'd4, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PIXEL_MODE, 14'd1,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_ROW_PIXELS, 14'd2,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_FRAME_ROWS, 14'd1,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PAD_BYTES,  14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd2, 48'h000000FFFFFF, 1'b1, 1'b1},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h21, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h43, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h65, 3'd2, 48'h000000654321, 1'b1, 1'b1},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hAA, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PIXEL_MODE, 14'h3FFE,  8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_ROW_PIXELS, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_FRAME_ROWS, 14'd0,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PAD_BYTES,  14'd1,     8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h12, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h34, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h56, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h78, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hFF, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h5A, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'hC3, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PIXEL_MODE, 14'h2AAB,  8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_ROW_PIXELS, 14'd16383, 8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_FRAME_ROWS, 14'd16383, 8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_REG,  REG_PAD_BYTES,  14'h3FFF,  8'h00, 3'd0, 48'h0, 1'b0, 1'b0},
    '{ROW_BYTE, REG_PIXEL_MODE, 14'd0,     8'h96, 3'd0, 48'h0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  raw_bit_packed_unpacker u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted register and unpacker state.
  logic        cur_mode  = MODE_RAW10;
  logic [13:0] cur_width = 14'd3840;
  logic [13:0] cur_rows  = 14'd2160;
  logic [11:0] cur_pad   = 12'd64;
  logic [31:0] gathered  = '0;
  logic [2:0]  grp_fill  = '0;
  logic [13:0] col_done  = '0;
  logic [13:0] row_done  = '0;
  logic [11:0] pad_left  = '0;
  logic        skipping  = 1'b0;

  pix_item_t pixels_due[$];

  int errors;
  int pixels_checked;
  int bytes_sent;
  int pad_seen;
  int reg_writes;
  int cycles;
  int burst_left;
  bit no_gaps;

  function automatic void apply_reg(input cfg_reg_t idx, input logic [13:0] val);
    case (idx)
      REG_PIXEL_MODE: cur_mode  = val[0];
      REG_ROW_PIXELS: cur_width = val;
      REG_FRAME_ROWS: cur_rows  = val;
      REG_PAD_BYTES:  cur_pad   = val[11:0];
      default: ;
    endcase
  endfunction

  // Advance the unpacker by one byte; queue the pixels it releases when record is set.
  function automatic void unpack_byte(input logic [7:0] b, input bit record);
    logic [7:0]  b0, b1, b2, b3;
    logic [11:0] px [4];
    int          npix, grp_bytes, width, rows;
    bit          rend, fend;
    if (skipping) begin
      if (pad_left != 0) pad_left = pad_left - 1'b1;
      if (pad_left == 0) skipping = 1'b0;
      return;
    end
    npix      = (cur_mode == MODE_RAW12) ? 2 : 4;
    grp_bytes = (cur_mode == MODE_RAW12) ? 3 : 5;
    if (int'(grp_fill) + 1 < grp_bytes) begin
      gathered = gathered | (32'(b) << (8 * grp_fill[1:0]));
      grp_fill = grp_fill + 1'b1;
      return;
    end
    {b3, b2, b1, b0} = gathered;
    if (cur_mode == MODE_RAW12) begin
      px[0] = {b1[3:0], b0};
      px[1] = {b, b1[7:4]};
      px[2] = '0;
      px[3] = '0;
    end else begin
      px[0] = {2'b00, b1[1:0], b0};
      px[1] = {2'b00, b2[3:0], b1[7:2]};
      px[2] = {2'b00, b3[5:0], b2[7:4]};
      px[3] = {2'b00, b, b3[7:6]};
    end
    gathered = '0;
    grp_fill = '0;
    width = (cur_width > 14'd8192) ? 8192 : int'(cur_width);
    rows  = (cur_rows > 14'd8192) ? 8192 : int'(cur_rows);
    rend  = 1'b0;
    fend  = 1'b0;
    if (int'(col_done) + npix >= width) begin
      rend     = 1'b1;
      col_done = '0;
      if (int'(row_done) + 1 >= rows) begin
        fend     = 1'b1;
        row_done = '0;
      end else begin
        row_done = row_done + 1'b1;
      end
      if (cur_pad != 0) begin
        skipping = 1'b1;
        pad_left = cur_pad;
      end
    end else begin
      col_done = col_done + 14'(npix);
    end
    if (record) begin
      for (int k = 0; k < npix; k++) begin
        pixels_due.push_back('{px[k], k == npix - 1, (k == npix - 1) && rend,
                               (k == npix - 1) && fend});
      end
    end
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Insert a random gap between bursts unless the phase runs back to back.
  task automatic pace();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left = $urandom_range(1, 16);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit record);
    pace();
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (skipping) pad_seen++;
    unpack_byte(b, record);
  endtask

  // Hold the input until every queued pixel is out, then let the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  // Output side: compare each accepted pixel against the oldest prediction.
  always @(posedge clk) begin
    pix_item_t exp_px;
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel: tdata=%04h last=%0b tuser=%02b",
                   m_tdata, m_tlast, m_tuser);
      end else begin
        exp_px = pixels_due.pop_front();
        pixels_checked++;
        if (m_tdata !== {4'h0, exp_px.pixel} || m_tlast !== exp_px.last ||
            m_tuser[0] !== exp_px.row_end || m_tuser[1] !== exp_px.frame_end) begin
          errors++;
          if (errors <= 10)
            $display("pixel %0d mismatch: expected px=%03h last=%0b row_end=%0b frame_end=%0b,%s",
                     pixels_checked, exp_px.pixel, exp_px.last, exp_px.row_end,
                     exp_px.frame_end, $sformatf(" got tdata=%04h last=%0b tuser=%02b",
                     m_tdata, m_tlast, m_tuser));
        end
      end
    end
  end

  // Receiver back-pressure: pick a random ready style and hold it for a random span.
  ready_style_t ready_style = READY_ALWAYS;
  int           style_left  = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 3));
      style_left  <= $urandom_range(20, 80);
    end else begin
      style_left <= style_left - 1;
    end
    case (ready_style)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
      READY_RARELY:   m_tready <= ($urandom_range(0, 3) == 0);
      READY_PERIODIC: m_tready <= cycles[2];
      default:        m_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycles, pixels_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    bit          mode;
    int          grp, n_items, counted;
    logic [13:0] width, rows, pad;
    errors         = 0;
    pixels_checked = 0;
    bytes_sent     = 0;
    pad_seen       = 0;
    reg_writes     = 0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_PIXEL_MODE;
    cfg_data       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_val);
      end else if (row.ntyped != 0) begin
        push_byte(row.data, 1'b0);
        for (int k = 0; k < int'(row.ntyped); k++) begin
          pixels_due.push_back('{row.px[k], k == row.ntyped - 1,
                                 (k == row.ntyped - 1) && row.row_end,
                                 (k == row.ntyped - 1) && row.frame_end});
        end
      end else begin
        push_byte(row.data, 1'b1);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      mode    = 1'($urandom_range(0, 1));
      grp     = mode ? 2 : 4;
      n_items = 22;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: width = 14'(grp * $urandom_range(1, 4));
        6, 7:             width = 14'($urandom_range(1, 9));
        8:                width = 14'd0;
        default:          width = 14'($urandom_range(2, 12));
      endcase
      rows = ($urandom_range(0, 5) == 0) ? 14'd0 : 14'($urandom_range(1, 4));
      pad  = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(1, 6));
      if (p == 4) begin
        width = 14'd8192;
        rows  = 14'd8192;
      end
      if (p == 6) begin
        // long padding: keep rows short and the item count low
        width   = 14'(grp * 2);
        pad     = 14'd16;
        n_items = 12;
      end
      write_reg(REG_PIXEL_MODE, (14'($urandom) & ~14'd1) | 14'(mode));
      write_reg(REG_ROW_PIXELS, width);
      write_reg(REG_FRAME_ROWS, rows);
      write_reg(REG_PAD_BYTES, pad | (14'($urandom_range(0, 3)) << 12));
      no_gaps = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < n_items) begin
        if (!skipping) counted++;
        push_byte(random_byte(), 1'b1);
        // pause mid-phase until the output side has caught up
        if (p == 2 && counted == 17) drain_results();
      end
    end

    drain_results();
    if (pixels_due.size() != 0) errors++;
    $display("Sent %0d bytes (%0d swallowed as row padding), checked %0d pixels,",
             bytes_sent, pad_seen, pixels_checked);
    $display("over %0d register writes in both packing modes incl. clamped and zero sizes.",
             reg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
